// ===== hdl/mafss_pkg.sv =====
// Shared constants, tables and controller/datapath interface types for the frame sync search.
package mafss_pkg;

	localparam int DEF_BUF_DEPTH = 4096;

	localparam logic [31:0] SYNC_MASK = 32'hffe00000;
	localparam logic [31:0] KEEP_MASK = 32'hfffe0c00;

	localparam int OFF_W      = 12;
	localparam int SIZE_W     = 13;
	localparam int QUO_W      = 12;
	localparam int NUM_W      = 26;
	localparam int DEN_W      = 16;
	localparam int REM_W      = NUM_W + 1;
	localparam int KBPS_W     = 9;
	localparam int WORD_BYTES = 4;
	localparam int MIN_SIZE   = 4;

	localparam int L1_SCALE  = 12000;
	localparam int L23_SCALE = 144000;

	localparam logic [KBPS_W-1:0] KBPS_TAB [0:5][0:14] = '{
		'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
		  9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448},
		'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		  9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384},
		'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		  9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320},
		'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		  9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
		'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160},
		'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160}
	};

	typedef enum logic {
		ADDR_WIN,
		ADDR_FOL
	} addr_sel_t;

	typedef struct packed {
		logic      store;
		logic      clr_p;
		logic      adv_p;
		logic      rd_en;
		addr_sel_t addr_sel;
		logic [2:0] idx;
		logic      shift_h;
		logic      shift_f;
		logic      mul;
		logic      div_init;
		logic      div_step;
		logic      size_latch;
		logic      res_latch;
		logic      res_found;
	} dp_cmd_t;

	typedef struct packed {
		logic in_range;
		logic hdr_ok;
		logic size_ok;
		logic fol_fits;
		logic fol_match;
	} dp_sts_t;

	// lay: 0 = layer I, 1 = layer II, 2 = layer III
	function automatic logic [KBPS_W-1:0] rate_kbps(logic low_sf, logic [1:0] lay,
		logic [3:0] bri);
		logic [2:0] row;
		row = low_sf ? (3'(lay) + 3'd3) : 3'(lay);
		if (bri == 4'hf || lay == 2'd3) begin
			return '0;
		end
		return KBPS_TAB[row][bri];
	endfunction

	function automatic logic [DEN_W-1:0] base_hz(logic [1:0] sri);
		logic [DEN_W-1:0] hz;
		case (sri)
			2'd0:    hz = DEN_W'(44100);
			2'd1:    hz = DEN_W'(48000);
			2'd2:    hz = DEN_W'(32000);
			default: hz = '0;
		endcase
		return hz;
	endfunction

endpackage

// ===== hdl/mpeg_audio_frame_sync_search_unit.sv =====
// Top level of the MPEG audio frame sync search: controller plus datapath.
//
// Input channel (in_valid/in_stall, data_byte, last_byte): one byte per
// transfer, one per cycle while loading. Bytes beyond BUF_DEPTH are dropped
// and flagged. The transfer with last_byte set starts the scan; in_stall
// stays high until the scan ends.
// Scan: load the first header window, then check the header at each
// position and advance past one that fails; for a header candidate,
// multiply, run the 12-step divider, test the size and, when it fits, read
// the following header back through the single store read port.
// Output channel (out_valid/out_stall, found, frame_offset, overflow): one
// transfer per buffer, valid the cycle after the scan ends and held while
// out_stall is high. Bytes of the next buffer are taken while it waits; a
// next last byte is stalled until the pending result has transferred.
// Reset: empty store, no pending result; store contents need no clearing.
module mpeg_audio_frame_sync_search_unit import mafss_pkg::*; #(
	parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             found,
	output logic [OFF_W-1:0] frame_offset,
	output logic             overflow
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	mafss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mafss_dp #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (data_byte),
		.cmd          (cmd),
		.sts          (sts),
		.found        (found),
		.frame_offset (frame_offset),
		.overflow     (overflow)
	);

endmodule

// ===== hdl/mafss_dp.sv =====
// Datapath: byte store, header window, frame size unit with serial divider, result registers.
module mafss_dp import mafss_pkg::*; #(
	parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        data_byte,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	output logic              found,
	output logic [OFF_W-1:0]  frame_offset,
	output logic              overflow
);

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CW = $clog2(BUF_DEPTH + 1);
	localparam int SW = ((CW > SIZE_W) ? CW : SIZE_W) + 2;

	logic [7:0]        mem [BUF_DEPTH];
	logic [7:0]        rd_q;
	logic [CW-1:0]     fill_q;
	logic              ovf_q;
	logic [AW-1:0]     p_q;
	logic [31:0]       h_q;
	logic [31:0]       f_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic              pad_q;
	logic              l1_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic [SIZE_W-1:0] size_q;
	logic              found_q;
	logic [OFF_W-1:0]  off_q;
	logic              ovf_res_q;

	logic              wr_en;
	logic [AW-1:0]     rd_addr;
	logic [SW-1:0]     p_x;
	logic [SW-1:0]     len_x;
	logic [SW-1:0]     size_x;
	logic              low_sf;
	logic              v25;
	logic [1:0]        lay;
	logic [1:0]        sri;
	logic [3:0]        bri;
	logic [1:0]        hz_shift;
	logic [DEN_W-1:0]  hz;
	logic [KBPS_W-1:0] kb;
	logic [SIZE_W-1:0] size_sum;

	assign wr_en  = cmd.store && (fill_q < CW'(BUF_DEPTH));
	assign p_x    = SW'(p_q);
	assign len_x  = SW'(fill_q);
	assign size_x = SW'(size_q);

	always_comb begin
		case (cmd.addr_sel)
			ADDR_FOL: rd_addr = AW'(p_x + size_x + SW'(cmd.idx));
			default:  rd_addr = AW'(p_x + SW'(cmd.idx));
		endcase
	end

	assign low_sf   = h_q[20] ? ~h_q[19] : 1'b1;
	assign v25      = ~h_q[20];
	assign lay      = 2'd3 - h_q[18:17];
	assign sri      = h_q[11:10];
	assign bri      = h_q[15:12];
	assign hz_shift = {1'b0, low_sf} + {1'b0, v25};
	assign hz       = base_hz(sri) >> hz_shift;
	assign kb       = rate_kbps(low_sf, lay, bri);
	assign size_sum = SIZE_W'(quo_q) + SIZE_W'(pad_q);

	assign sts.in_range  = (p_x + SW'(WORD_BYTES)) < len_x;
	assign sts.hdr_ok    = ((h_q & SYNC_MASK) == SYNC_MASK) && (h_q[18:17] != 2'd0)
		&& (bri != 4'hf) && (sri != 2'd3);
	assign sts.size_ok   = size_q > SIZE_W'(MIN_SIZE);
	assign sts.fol_fits  = (p_x + size_x + SW'(WORD_BYTES)) <= len_x;
	assign sts.fol_match = (f_q & KEEP_MASK) == (h_q & KEEP_MASK);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[AW-1:0]] <= data_byte;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
			p_q    <= '0;
		end else begin
			if (cmd.store) begin
				if (wr_en) begin
					fill_q <= fill_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.res_latch) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end
			if (cmd.clr_p) begin
				p_q <= '0;
			end else if (cmd.adv_p) begin
				p_q <= p_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_h) begin
			h_q <= {h_q[23:0], rd_q};
		end
		if (cmd.shift_f) begin
			f_q <= {f_q[23:0], rd_q};
		end
		if (cmd.mul) begin
			num_q <= (lay == 2'd0) ? NUM_W'(NUM_W'(kb) * NUM_W'(L1_SCALE))
				: NUM_W'(NUM_W'(kb) * NUM_W'(L23_SCALE));
			den_q <= (lay == 2'd2) ? (hz << low_sf) : hz;
			pad_q <= h_q[9];
			l1_q  <= lay == 2'd0;
		end
		if (cmd.div_init) begin
			rem_q <= REM_W'(num_q);
			dsh_q <= REM_W'(den_q) << (QUO_W - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.size_latch) begin
			size_q <= l1_q ? (size_sum << 2) : size_sum;
		end
		if (cmd.res_latch) begin
			found_q   <= cmd.res_found;
			off_q     <= cmd.res_found ? OFF_W'(p_q) : '0;
			ovf_res_q <= ovf_q;
		end
	end

	assign found        = found_q;
	assign frame_offset = off_q;
	assign overflow     = ovf_res_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(BUF_DEPTH))
		else $error("fill count beyond store depth");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (fill_q == CW'(BUF_DEPTH)))
		else $error("overflow flagged while store not full");

	a_res_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_latch |=> (fill_q == '0) && !ovf_q)
		else $error("buffer state not cleared after result");

endmodule

// ===== hdl/mafss_ctrl.sv =====
// Controller: load handshake, scan sequencing and output valid.
module mafss_ctrl import mafss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    last_byte,
	output logic    out_valid,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam int CNT_W = $clog2(QUO_W);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PRIME,
		ST_CHECK,
		ST_ADV,
		ST_NEXT,
		ST_SHIFT,
		ST_MUL,
		ST_DINIT,
		ST_DIV,
		ST_SIZE,
		ST_TEST,
		ST_FOL,
		ST_CMP
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_LOAD: begin
				in_stall = out_valid_q && last_byte;
				if (in_valid && !in_stall) begin
					cmd.store = 1'b1;
					if (last_byte) begin
						cmd.clr_p = 1'b1;
						cnt_d     = '0;
						state_d   = ST_PRIME;
					end
				end
			end
			ST_PRIME: begin
				if (cnt_q == '0 && !sts.in_range) begin
					cmd.res_latch = 1'b1;
					state_d       = ST_LOAD;
				end else begin
					if (cnt_q < CNT_W'(WORD_BYTES)) begin
						cmd.rd_en    = 1'b1;
						cmd.addr_sel = ADDR_WIN;
						cmd.idx      = cnt_q[2:0];
					end
					cmd.shift_h = cnt_q != '0;
					if (cnt_q == CNT_W'(WORD_BYTES)) begin
						state_d = ST_CHECK;
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
			end
			ST_CHECK: begin
				state_d = sts.hdr_ok ? ST_MUL : ST_ADV;
			end
			ST_ADV: begin
				cmd.adv_p = 1'b1;
				state_d   = ST_NEXT;
			end
			ST_NEXT: begin
				if (!sts.in_range) begin
					cmd.res_latch = 1'b1;
					state_d       = ST_LOAD;
				end else begin
					cmd.rd_en    = 1'b1;
					cmd.addr_sel = ADDR_WIN;
					cmd.idx      = 3'(WORD_BYTES - 1);
					state_d      = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.shift_h = 1'b1;
				state_d     = ST_CHECK;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					state_d = ST_SIZE;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_SIZE: begin
				cmd.size_latch = 1'b1;
				state_d        = ST_TEST;
			end
			ST_TEST: begin
				if (!sts.size_ok) begin
					state_d = ST_ADV;
				end else if (!sts.fol_fits) begin
					cmd.res_latch = 1'b1;
					cmd.res_found = 1'b1;
					state_d       = ST_LOAD;
				end else begin
					cnt_d   = '0;
					state_d = ST_FOL;
				end
			end
			ST_FOL: begin
				if (cnt_q < CNT_W'(WORD_BYTES)) begin
					cmd.rd_en    = 1'b1;
					cmd.addr_sel = ADDR_FOL;
					cmd.idx      = cnt_q[2:0];
				end
				cmd.shift_f = cnt_q != '0;
				if (cnt_q == CNT_W'(WORD_BYTES)) begin
					state_d = ST_CMP;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_CMP: begin
				if (sts.fol_match) begin
					cmd.res_latch = 1'b1;
					cmd.res_found = 1'b1;
					state_d       = ST_LOAD;
				end else begin
					state_d = ST_ADV;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.res_latch) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_no_out_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !out_valid_q)
		else $error("result pending during scan");

	a_valid_from_latch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.res_latch))
		else $error("output valid raised without result latch");

	a_scan_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !cmd.store)
		else $error("byte stored during scan");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the MPEG audio frame sync search unit.
module testbench;

	localparam int unsigned STORE_DEPTH = 4096;
	localparam int unsigned RAND_BYTES  = 780;
	localparam int unsigned RAND_BUFS   = 8;
	localparam int unsigned DRAIN       = 40;
	localparam int unsigned LIMIT       = 2_000_000;

	localparam logic [31:0] HDR_SYNC = 32'hffe00000;
	localparam logic [31:0] HDR_KEEP = 32'hfffe0c00;

	localparam int unsigned RATE_KBPS [6][15] = '{
		'{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
		'{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
		'{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320},
		'{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
		'{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160},
		'{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}
	};
	localparam int unsigned RATE_HZ [3] = '{44100, 48000, 32000};

	typedef enum logic [1:0] {
		FOL_NONE,
		FOL_MATCH,
		FOL_BREAK
	} follower_t;

	typedef struct packed {
		logic                       found;
		logic [mafss_pkg::OFF_W-1:0] offset;
		logic                       ovf;
	} sync_result_t;

	typedef struct packed {
		logic [12:0]  len;
		logic [12:0]  pos;
		logic [31:0]  hdr;
		logic [7:0]   fill;
		follower_t    fol;
		logic         typed;
		sync_result_t res;
	} buf_case_t;

	// len, header position, header, filler, follower, typed, expected result
	localparam buf_case_t BUF_CASES [17] = '{
		'{13'd1,    13'd1,    32'h00000000, 8'h00, FOL_NONE,  1'b1, '{1'b0, 12'd0, 1'b0}},
		'{13'd4,    13'd0,    32'hfffb9064, 8'h00, FOL_NONE,  1'b1, '{1'b0, 12'd0, 1'b0}},
		'{13'd5,    13'd0,    32'hfffb9064, 8'h00, FOL_NONE,  1'b1, '{1'b1, 12'd0, 1'b0}},
		'{13'd8,    13'd8,    32'h00000000, 8'hff, FOL_NONE,  1'b1, '{1'b0, 12'd0, 1'b0}},
		'{13'd8,    13'd1,    32'hfffb0064, 8'h00, FOL_NONE,  1'b1, '{1'b0, 12'd0, 1'b0}},
		'{13'd8,    13'd0,    32'hfff99064, 8'h00, FOL_NONE,  1'b1, '{1'b0, 12'd0, 1'b0}},
		'{13'd8,    13'd0,    32'hfffbf064, 8'h00, FOL_NONE,  1'b1, '{1'b0, 12'd0, 1'b0}},
		'{13'd8,    13'd0,    32'hfffb9c64, 8'h00, FOL_NONE,  1'b1, '{1'b0, 12'd0, 1'b0}},
		'{13'd8,    13'd0,    32'hffdb9064, 8'h00, FOL_NONE,  1'b1, '{1'b0, 12'd0, 1'b0}},
		'{13'd110,  13'd3,    32'hfffb1464, 8'h00, FOL_MATCH, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{13'd110,  13'd3,    32'hfffb1464, 8'h00, FOL_BREAK, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{13'd110,  13'd5,    32'hfff34464, 8'h00, FOL_MATCH, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{13'd110,  13'd2,    32'hffe32464, 8'h00, FOL_MATCH, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{13'd110,  13'd2,    32'hffeb2464, 8'h00, FOL_BREAK, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{13'd50,   13'd0,    32'hffff1664, 8'h00, FOL_MATCH, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{13'd12,   13'd7,    32'hfffd9064, 8'h00, FOL_NONE,  1'b1, '{1'b1, 12'd7, 1'b0}},
		'{13'd6,    13'd1,    32'hfffb9064, 8'h00, FOL_NONE,  1'b1, '{1'b1, 12'd1, 1'b0}}
	};

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [7:0]                  data_byte = 8'h00;
	logic                        last_byte = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic                        found;
	logic [mafss_pkg::OFF_W-1:0] frame_offset;
	logic                        overflow;

	logic [7:0]   shadow_mem [STORE_DEPTH];
	int unsigned  shadow_fill = 0;
	logic         shadow_ovf = 1'b0;
	logic [7:0]   frame_bytes_q [$];
	sync_result_t pending_results [$];

	int unsigned n_bytes = 0;
	int unsigned n_bufs = 0;
	int unsigned n_hits = 0;
	int unsigned n_ovf = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;
	bit          steady = 1'b0;
	int unsigned rx_left = 0;

	mpeg_audio_frame_sync_search_unit #(
		.BUF_DEPTH(STORE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.frame_offset(frame_offset),
		.overflow(overflow)
	);

	always #10 clk = ~clk;

	function automatic int unsigned frame_len(logic [31:0] h);
		int unsigned lsf;
		int unsigned v25;
		int unsigned lay;
		int unsigned hz;
		int unsigned kb;
		if (h[20]) begin
			lsf = h[19] ? 0 : 1;
			v25 = 0;
		end else begin
			lsf = 1;
			v25 = 1;
		end
		lay = 4 - h[18:17];
		if (lay == 4 || h[11:10] == 2'd3 || h[15:12] == 4'd0 || h[15:12] == 4'hf) begin
			return 0;
		end
		hz = RATE_HZ[h[11:10]] >> (lsf + v25);
		kb = RATE_KBPS[lsf * 3 + lay - 1][h[15:12]];
		if (lay == 1) begin
			return ((kb * 12000) / hz + h[9]) * 4;
		end
		if (lay == 2) begin
			return (kb * 144000) / hz + h[9];
		end
		return (kb * 144000) / (hz << lsf) + h[9];
	endfunction

	function automatic logic [31:0] word_at(int unsigned p);
		return {shadow_mem[p], shadow_mem[p + 1], shadow_mem[p + 2], shadow_mem[p + 3]};
	endfunction

	function automatic sync_result_t find_header();
		sync_result_t r;
		logic [31:0]  h;
		int unsigned  sz;
		r = '{found: 1'b0, offset: '0, ovf: shadow_ovf};
		for (int unsigned p = 0; p + 4 < shadow_fill; p++) begin
			h = word_at(p);
			if ((h & HDR_SYNC) != HDR_SYNC || h[18:17] == 2'd0) continue;
			if (h[15:12] == 4'hf || h[11:10] == 2'd3) continue;
			sz = frame_len(h);
			if (sz <= 4) continue;
			if (p + sz + 4 <= shadow_fill && (word_at(p + sz) & HDR_KEEP) != (h & HDR_KEEP)) continue;
			r.found = 1'b1;
			r.offset = p[mafss_pkg::OFF_W-1:0];
			return r;
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_header();
		logic [31:0] h;
		h = $urandom;
		h[31:21] = '1;
		if ($urandom_range(0, 4) != 0) begin
			if (h[18:17] == 2'd0) h[17] = 1'b1;
			h[15:12] = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(1, 4))
				: 4'($urandom_range(1, 14));
			if (h[11:10] == 2'd3) h[11:10] = 2'($urandom_range(0, 2));
		end
		return h;
	endfunction

	function automatic logic [31:0] follower_of(logic [31:0] h, logic match);
		logic [31:0] f;
		int unsigned b;
		f = (h & HDR_KEEP) | ($urandom & ~HDR_KEEP);
		if (!match) begin
			do b = $urandom_range(10, 31); while (!HDR_KEEP[b]);
			f[b] = ~f[b];
		end
		return f;
	endfunction

	function automatic logic [7:0] noise_byte();
		return ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
	endfunction

	task automatic put_word(int unsigned p, logic [31:0] w);
		for (int unsigned i = 0; i < 4; i++) begin
			if (p + i < frame_bytes_q.size()) frame_bytes_q[p + i] = w[31 - 8 * i -: 8];
		end
	endtask

	task automatic build_case(buf_case_t c);
		frame_bytes_q.delete();
		repeat (c.len) frame_bytes_q.push_back(c.fill);
		if (c.pos < c.len) put_word(c.pos, c.hdr);
		if (c.fol != FOL_NONE) put_word(c.pos + frame_len(c.hdr), follower_of(c.hdr, c.fol == FOL_MATCH));
	endtask

	task automatic build_random_buffer();
		int unsigned kind;
		int unsigned len;
		int unsigned pos;
		int unsigned sz;
		logic [31:0] h;
		kind = $urandom_range(0, 9);
		frame_bytes_q.delete();
		if (kind < 2) begin
			len = $urandom_range(1, 40);
			repeat (len) frame_bytes_q.push_back(noise_byte());
		end else if (kind < 7) begin
			h = rand_header();
			sz = frame_len(h);
			pos = $urandom_range(0, 6);
			if (sz > 4 && sz <= 300) len = pos + sz + 4 + $urandom_range(0, 5);
			else len = pos + $urandom_range(5, 30);
			repeat (len) frame_bytes_q.push_back(noise_byte());
			put_word(pos, h);
			if (sz > 4 && pos + sz + 4 <= len) put_word(pos + sz, follower_of(h, $urandom_range(0, 3) != 0));
			if ($urandom_range(0, 3) == 0) put_word($urandom_range(0, len - 1), rand_header());
		end else begin
			len = $urandom_range(5, 60);
			repeat (len) frame_bytes_q.push_back(8'($urandom));
			repeat ($urandom_range(1, 3)) put_word($urandom_range(0, len - 4), rand_header());
		end
	endtask

	task automatic take_byte(logic [7:0] b, logic lst, logic typed, sync_result_t typed_res);
		sync_result_t r;
		n_bytes++;
		if (shadow_fill < STORE_DEPTH) begin
			shadow_mem[shadow_fill] = b;
			shadow_fill++;
		end else begin
			shadow_ovf = 1'b1;
		end
		if (lst) begin
			r = find_header();
			pending_results.push_back(typed ? typed_res : r);
			n_bufs++;
			if (r.found) n_hits++;
			if (r.ovf) n_ovf++;
			shadow_fill = 0;
			shadow_ovf = 1'b0;
		end
	endtask

	task automatic send_buffer(logic typed, sync_result_t typed_res);
		int unsigned gap;
		for (int unsigned i = 0; i < frame_bytes_q.size(); i++) begin
			in_valid <= 1'b1;
			data_byte <= frame_bytes_q[i];
			last_byte <= (i == frame_bytes_q.size() - 1);
			do @(posedge clk); while (in_stall);
			take_byte(frame_bytes_q[i], i == frame_bytes_q.size() - 1, typed, typed_res);
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				steady = ($urandom_range(0, 5) == 0);
				gap = steady ? 0 : $urandom_range(0, 6);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end else begin
				burst_left--;
			end
		end
	endtask

	always @(posedge clk) begin
		sync_result_t e;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: found %0d offset %0d overflow %0d",
					found, frame_offset, overflow);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (found !== e.found) begin
					$error("found: expected %0d, got %0d", e.found, found);
					errors++;
				end
				if (frame_offset !== e.offset) begin
					$error("frame_offset: expected %0d, got %0d", e.offset, frame_offset);
					errors++;
				end
				if (overflow !== e.ovf) begin
					$error("overflow: expected %0d, got %0d", e.ovf, overflow);
					errors++;
				end
			end
		end
		if (rx_left == 0) begin
			if ($urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				rx_left = $urandom_range(1, 25);
			end else begin
				out_stall <= 1'b0;
				rx_left = $urandom_range(1, 60);
			end
		end else begin
			rx_left--;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		int unsigned rand_start;
		int unsigned bufs_start;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (BUF_CASES[i]) begin
			build_case(BUF_CASES[i]);
			send_buffer(BUF_CASES[i].typed, BUF_CASES[i].res);
		end
		rand_start = n_bytes;
		bufs_start = n_bufs;
		while (n_bytes - rand_start < RAND_BYTES || n_bufs - bufs_start < RAND_BUFS) begin
			build_random_buffer();
			send_buffer(1'b0, '0);
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("checked %0d buffers of %0d bytes in total", n_bufs, n_bytes);
		$display("headers located in %0d buffers, store overrun in %0d", n_hits, n_ovf);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
